@@ rtl/core/odo_pkg.sv @@
// shared types, constants and helper functions for the wheel odometry block
package odo_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int CW           = 34;     // cordic datapath width
    localparam int CFG_W        = 32;
    localparam int CFG_IDX_W    = 3;

    localparam logic [31:0] DPT_RESET  = 32'd125550;
    localparam logic [23:0] APT_RESET  = 24'd63030;
    localparam logic [23:0] MWR_RESET  = 24'd102630;
    localparam logic [30:0] MTS_RESET  = 31'd341782638;
    localparam logic [3:0]  DLIM_RESET = 4'd10;

    // cordic start value: gain-compensated unit vector in Q1.30
    localparam logic signed [CW-1:0] CORDIC_X0 = 34'sd652032874;
    // smallest |dd| * distance_per_tick that means at least 1 mm of turn path
    localparam logic [47:0] MAG_MIN = 48'd4294968;
    localparam logic [19:0] US_PER_S = 20'd1000000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIST_PER_TICK = 3'd0,
        CFG_ANGLE_PER_TICK = 3'd1,
        CFG_MAX_WHEEL_RATE = 3'd2,
        CFG_MAX_TURN_STEP = 3'd3,
        CFG_DROP_LIMIT = 3'd4,
        CFG_SPEED_SCALE = 3'd5,
        CFG_TURN_SCALE = 3'd6
    } cfg_idx_t;

    typedef enum logic [2:0] {
        RS_UPDATED = 3'd0,
        RS_DROPPED = 3'd1,
        RS_STALE   = 3'd2,
        RS_ZERO    = 3'd3,
        RS_INIT    = 3'd4
    } res_status_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_CHECK, ST_LIN, ST_ROT, ST_INIT, ST_RLO, ST_RHI, ST_FAST,
        ST_MAG, ST_TURN, ST_TCHK, ST_DIST, ST_CORDIC, ST_MX, ST_MY,
        ST_COMMIT, ST_PUB
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE, OP_LOAD, OP_CHECK, OP_LIN, OP_ROT, OP_INIT, OP_RLO, OP_RHI,
        OP_MAG, OP_TURN, OP_DIST, OP_CORDIC, OP_MX, OP_MY, OP_COMMIT, OP_PUB
    } dp_op_t;

    typedef struct packed {
        dp_op_t      op;
        logic        dc_inc;
        logic        dc_clr;
        logic        zero_spd;
        res_status_t code;
    } cmd_t;

    typedef struct packed {
        logic stale;
        logic zero_cnt;
        logic started;
        logic fast;
        logic turn_big;
        logic dc_below;
        logic cordic_last;
    } stat_t;

    function automatic logic [31:0] atan_val(input logic [4:0] i);
        logic [31:0] r;
        case (i)
            5'd0:  r = 32'd536870912;
            5'd1:  r = 32'd316933406;
            5'd2:  r = 32'd167458907;
            5'd3:  r = 32'd85004756;
            5'd4:  r = 32'd42667331;
            5'd5:  r = 32'd21354465;
            5'd6:  r = 32'd10680862;
            5'd7:  r = 32'd5340245;
            5'd8:  r = 32'd2670163;
            5'd9:  r = 32'd1335087;
            5'd10: r = 32'd667544;
            5'd11: r = 32'd333772;
            5'd12: r = 32'd166886;
            5'd13: r = 32'd83443;
            5'd14: r = 32'd41722;
            5'd15: r = 32'd20861;
            5'd16: r = 32'd10430;
            5'd17: r = 32'd5215;
            5'd18: r = 32'd2608;
            5'd19: r = 32'd1304;
            5'd20: r = 32'd652;
            5'd21: r = 32'd326;
            5'd22: r = 32'd163;
            5'd23: r = 32'd81;
            5'd24: r = 32'd41;
            5'd25: r = 32'd20;
            5'd26: r = 32'd10;
            5'd27: r = 32'd5;
            5'd28: r = 32'd3;
            5'd29: r = 32'd1;
            5'd30: r = 32'd1;
            default: r = 32'd0;
        endcase
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        logic [31:0] r;
        if (v > 72'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -72'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ rtl/core/odo_ifs.sv @@
// measurement and pose channel interfaces
interface odo_meas_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_count;
    logic signed [15:0] right_count;
    logic signed [15:0] left_speed;
    logic signed [15:0] right_speed;
    logic [47:0]        sample_time;

    modport source (output valid, left_count, right_count, left_speed, right_speed,
                    sample_time, input ready);
    modport sink (input valid, left_count, right_count, left_speed, right_speed,
                  sample_time, output ready);
endinterface

interface odo_pose_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] heading;
    logic signed [31:0] lin_speed;
    logic signed [31:0] rot_speed;
    logic [2:0]         status;

    modport source (output valid, pos_x, pos_y, heading, lin_speed, rot_speed, status,
                    input ready);
    modport sink (input valid, pos_x, pos_y, heading, lin_speed, rot_speed, status,
                  output ready);
endinterface

@@ rtl/core/odo_ctrl.sv @@
// sequencing state machine for the odometry update
module odo_ctrl
    import odo_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  meas_valid,
    output logic  meas_ready,
    output logic  pose_valid,
    input  logic  pose_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    state_t      state_reg, state_next;
    res_status_t code_reg, code_next;
    logic        ovalid_reg, ovalid_next;
    logic        pub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            code_reg   <= RS_UPDATED;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            code_reg   <= code_next;
            ovalid_reg <= ovalid_next;
        end
    end

    assign pub = (state_reg == ST_PUB) && (!ovalid_reg || pose_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (meas_valid) state_next = ST_CHECK;
            ST_CHECK:  state_next = (stat.stale || stat.zero_cnt) ? ST_PUB : ST_LIN;
            ST_LIN:    state_next = ST_ROT;
            ST_ROT:    state_next = stat.started ? ST_RLO : ST_INIT;
            ST_INIT:   state_next = ST_PUB;
            ST_RLO:    state_next = ST_RHI;
            ST_RHI:    state_next = ST_FAST;
            ST_FAST:   state_next = (stat.fast && stat.dc_below) ? ST_PUB : ST_MAG;
            ST_MAG:    state_next = ST_TURN;
            ST_TURN:   state_next = ST_TCHK;
            ST_TCHK:   state_next = (stat.turn_big && stat.dc_below) ? ST_PUB : ST_DIST;
            ST_DIST:   state_next = ST_CORDIC;
            ST_CORDIC: if (stat.cordic_last) state_next = ST_MX;
            ST_MX:     state_next = ST_MY;
            ST_MY:     state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_PUB;
            ST_PUB:    if (pub) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd          = '0;
        cmd.op       = OP_NONE;
        cmd.code     = code_reg;
        cmd.zero_spd = (code_reg == RS_STALE) || (code_reg == RS_ZERO);
        code_next    = code_reg;
        case (state_reg)
            ST_IDLE:   if (meas_valid) cmd.op = OP_LOAD;
            ST_CHECK:
            begin
                cmd.op = OP_CHECK;
                if (stat.stale)
                    code_next = RS_STALE;
                else if (stat.zero_cnt)
                    code_next = RS_ZERO;
            end
            ST_LIN:    cmd.op = OP_LIN;
            ST_ROT:    cmd.op = OP_ROT;
            ST_INIT:
            begin
                cmd.op    = OP_INIT;
                code_next = RS_INIT;
            end
            ST_RLO:    cmd.op = OP_RLO;
            ST_RHI:    cmd.op = OP_RHI;
            ST_FAST:
            begin
                if (stat.fast)
                begin
                    cmd.dc_inc = stat.dc_below;
                    cmd.dc_clr = !stat.dc_below;
                    if (stat.dc_below) code_next = RS_DROPPED;
                end
            end
            ST_MAG:    cmd.op = OP_MAG;
            ST_TURN:   cmd.op = OP_TURN;
            ST_TCHK:
            begin
                if (stat.turn_big)
                begin
                    cmd.dc_inc = stat.dc_below;
                    cmd.dc_clr = !stat.dc_below;
                    if (stat.dc_below) code_next = RS_DROPPED;
                end
            end
            ST_DIST:   cmd.op = OP_DIST;
            ST_CORDIC: cmd.op = OP_CORDIC;
            ST_MX:     cmd.op = OP_MX;
            ST_MY:     cmd.op = OP_MY;
            ST_COMMIT:
            begin
                cmd.op    = OP_COMMIT;
                code_next = RS_UPDATED;
            end
            ST_PUB:    if (pub) cmd.op = OP_PUB;
            default:   cmd.op = OP_NONE;
        endcase
    end

    assign ovalid_next = pub || (ovalid_reg && !pose_ready);
    assign meas_ready  = (state_reg == ST_IDLE);
    assign pose_valid  = ovalid_reg;

endmodule

@@ rtl/core/odo_dp.sv @@
// odometry datapath: config registers, pose state, multipliers and cordic unit
module odo_dp
    import odo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    input  logic signed [15:0]   left_count,
    input  logic signed [15:0]   right_count,
    input  logic signed [15:0]   left_speed,
    input  logic signed [15:0]   right_speed,
    input  logic [47:0]          sample_time,
    input  cmd_t                 cmd,
    output stat_t                stat,
    output logic signed [31:0]   pos_x,
    output logic signed [31:0]   pos_y,
    output logic signed [31:0]   heading,
    output logic signed [31:0]   lin_speed,
    output logic signed [31:0]   rot_speed,
    output logic [2:0]           status
);

    // configuration
    logic [31:0] dpt_reg, sscale_reg, tscale_reg;
    logic [23:0] apt_reg, mwr_reg;
    logic [30:0] mts_reg;
    logic [3:0]  dlim_reg;

    // persistent state
    logic signed [15:0] prev_left_reg, prev_right_reg;
    logic               started_reg;
    logic [3:0]         dc_reg;
    logic [47:0]        prev_time_reg;
    logic signed [31:0] acc_x_reg, acc_y_reg;
    logic [31:0]        acc_hd_reg;

    // item and work registers
    logic signed [15:0] lc_reg, rc_reg, ls_reg, rs_reg;
    logic [47:0]        t_reg, dt_reg, plo_reg, m1_reg;
    logic signed [16:0] dl_reg, dr_reg, dd_reg, sum_reg;
    logic signed [31:0] tv_reg, rv_reg, dist_reg, newx_reg;
    logic [71:0]        rate_reg;
    logic signed [41:0] turn_reg;
    logic signed [CW-1:0] cx_reg, cy_reg, cz_reg;
    logic               flip_reg;
    logic [5:0]         iter_reg;
    logic signed [65:0] prod_reg;
    logic signed [31:0] res_x_reg, res_y_reg, res_hd_reg, res_tv_reg, res_rv_reg;
    logic [2:0]         res_st_reg;

    function automatic logic signed [16:0] fold16(input logic signed [15:0] d);
        logic signed [16:0] e;
        e = {d[15], d};
        if (e > 17'sd16383)
            e = e - 17'sd32768;
        if (e < -17'sd16383)
            e = e + 17'sd32768;
        return e;
    endfunction

    function automatic logic [15:0] abs17(input logic signed [16:0] d);
        logic signed [16:0] a;
        a = d[16] ? -d : d;
        return a[15:0];
    endfunction

    logic signed [15:0] dl16, dr16;
    logic signed [16:0] sum_sp, dif_sp;
    logic signed [49:0] p_lin, p_rot, p_dist, r_lin, r_dist;
    logic [35:0]        a_l, a_r;
    logic [47:0]        p_hi;
    logic signed [41:0] turn_raw;
    logic [31:0]        ang_f;
    logic               flip_c;
    logic [4:0]         ci;
    logic signed [CW-1:0] xs, ys, atan_e, c_eff, s_eff;
    logic signed [65:0] r_pos;
    logic signed [71:0] sum_pos;

    always_comb
    begin
        dl16     = lc_reg - prev_left_reg;
        dr16     = rc_reg - prev_right_reg;
        sum_sp   = 17'(ls_reg) + 17'(rs_reg);
        dif_sp   = 17'(rs_reg) - 17'(ls_reg);
        p_lin    = sum_sp * $signed({1'b0, sscale_reg});
        r_lin    = (p_lin + 50'sd1) >>> 1;
        p_rot    = dif_sp * $signed({1'b0, tscale_reg});
        p_dist   = sum_reg * $signed({1'b0, dpt_reg});
        r_dist   = (p_dist + 50'sd65536) >>> 17;
        p_hi     = mwr_reg * dt_reg[47:24];
        a_l      = abs17(dl_reg) * US_PER_S;
        a_r      = abs17(dr_reg) * US_PER_S;
        turn_raw = dd_reg * $signed({1'b0, apt_reg});
        flip_c   = (acc_hd_reg >= 32'h4000_0000) && (acc_hd_reg < 32'hC000_0000);
        ang_f    = flip_c ? acc_hd_reg + 32'h8000_0000 : acc_hd_reg;
        ci       = iter_reg[4:0];
        xs       = cx_reg >>> ci;
        ys       = cy_reg >>> ci;
        atan_e   = $signed({2'b00, atan_val(ci)});
        c_eff    = flip_reg ? -cx_reg : cx_reg;
        s_eff    = flip_reg ? -cy_reg : cy_reg;
        r_pos    = (prod_reg + 66'sd536870912) >>> 30;
        sum_pos  = 72'(r_pos) + 72'(cmd.op == OP_MY ? acc_x_reg : acc_y_reg);
    end

    always_comb
    begin
        stat.stale       = (prev_time_reg >= t_reg);
        stat.zero_cnt    = (lc_reg == 16'sd0) || (rc_reg == 16'sd0);
        stat.started     = started_reg;
        stat.fast        = ({36'd0, a_l} > rate_reg) || ({36'd0, a_r} > rate_reg);
        stat.turn_big    = turn_reg > $signed({11'd0, mts_reg});
        stat.dc_below    = (dc_reg < dlim_reg);
        stat.cordic_last = (iter_reg == 6'(CORDIC_STEPS - 1));
    end

    // control and persistent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpt_reg        <= DPT_RESET;
            apt_reg        <= APT_RESET;
            mwr_reg        <= MWR_RESET;
            mts_reg        <= MTS_RESET;
            dlim_reg       <= DLIM_RESET;
            sscale_reg     <= '0;
            tscale_reg     <= '0;
            prev_left_reg  <= '0;
            prev_right_reg <= '0;
            started_reg    <= 1'b0;
            dc_reg         <= '0;
            prev_time_reg  <= '0;
            acc_x_reg      <= '0;
            acc_y_reg      <= '0;
            acc_hd_reg     <= '0;
            iter_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_DIST_PER_TICK:  dpt_reg    <= cfg_wdata;
                    CFG_ANGLE_PER_TICK: apt_reg    <= cfg_wdata[23:0];
                    CFG_MAX_WHEEL_RATE: mwr_reg    <= cfg_wdata[23:0];
                    CFG_MAX_TURN_STEP:  mts_reg    <= cfg_wdata[30:0];
                    CFG_DROP_LIMIT:     dlim_reg   <= cfg_wdata[3:0];
                    CFG_SPEED_SCALE:    sscale_reg <= cfg_wdata;
                    CFG_TURN_SCALE:     tscale_reg <= cfg_wdata;
                    default:            dlim_reg   <= dlim_reg;
                endcase
            end
            if (cmd.dc_inc)
                dc_reg <= dc_reg + 4'd1;
            else if (cmd.dc_clr)
                dc_reg <= '0;
            case (cmd.op)
                OP_INIT:
                begin
                    prev_left_reg  <= lc_reg;
                    prev_right_reg <= rc_reg;
                    started_reg    <= 1'b1;
                    acc_x_reg      <= '0;
                    acc_y_reg      <= '0;
                    acc_hd_reg     <= '0;
                end
                OP_DIST:   iter_reg <= '0;
                OP_CORDIC: iter_reg <= iter_reg + 6'd1;
                OP_COMMIT:
                begin
                    acc_x_reg      <= newx_reg;
                    acc_y_reg      <= sat32(sum_pos);
                    acc_hd_reg     <= acc_hd_reg + turn_reg[31:0];
                    prev_left_reg  <= lc_reg;
                    prev_right_reg <= rc_reg;
                    prev_time_reg  <= t_reg;
                    if (dc_reg != 4'd0)
                        dc_reg <= dc_reg - 4'd1;
                end
                default: iter_reg <= iter_reg;
            endcase
        end
    end

    // work registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_LOAD:
            begin
                lc_reg <= left_count;
                rc_reg <= right_count;
                ls_reg <= left_speed;
                rs_reg <= right_speed;
                t_reg  <= sample_time;
            end
            OP_CHECK:
            begin
                dl_reg  <= fold16(dl16);
                dr_reg  <= fold16(dr16);
                dd_reg  <= fold16(dl16) - fold16(dr16);
                sum_reg <= fold16(dl16) + fold16(dr16);
                dt_reg  <= t_reg - prev_time_reg;
            end
            OP_LIN:  tv_reg   <= sat32(72'(r_lin));
            OP_ROT:  rv_reg   <= sat32(72'(p_rot));
            OP_RLO:  plo_reg  <= mwr_reg * dt_reg[23:0];
            OP_RHI:  rate_reg <= {24'd0, plo_reg} + {p_hi, 24'd0};
            OP_MAG:  m1_reg   <= abs17(dd_reg) * dpt_reg;
            OP_TURN: turn_reg <= (m1_reg >= MAG_MIN) ? turn_raw : 42'sd0;
            OP_DIST:
            begin
                dist_reg <= r_dist[31:0];
                flip_reg <= flip_c;
                cx_reg   <= CORDIC_X0;
                cy_reg   <= '0;
                cz_reg   <= CW'($signed(ang_f));
            end
            OP_CORDIC:
            begin
                if (!cz_reg[CW-1])
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_e;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_e;
                end
            end
            OP_MX: prod_reg <= dist_reg * c_eff;
            OP_MY:
            begin
                newx_reg <= sat32(sum_pos);
                prod_reg <= dist_reg * s_eff;
            end
            OP_PUB:
            begin
                res_x_reg  <= acc_x_reg;
                res_y_reg  <= acc_y_reg;
                res_hd_reg <= acc_hd_reg;
                res_tv_reg <= cmd.zero_spd ? 32'sd0 : tv_reg;
                res_rv_reg <= cmd.zero_spd ? 32'sd0 : rv_reg;
                res_st_reg <= cmd.code;
            end
            default: res_st_reg <= res_st_reg;
        endcase
    end

    assign pos_x     = res_x_reg;
    assign pos_y     = res_y_reg;
    assign heading   = res_hd_reg;
    assign lin_speed = res_tv_reg;
    assign rot_speed = res_rv_reg;
    assign status    = res_st_reg;

endmodule

@@ rtl/core/diff_drive_odometry_top.sv @@
// throughput: one beat at a time; the next is taken once the state machine is back
// in idle, so the iterative cordic (one rotation per cycle) sets the update rate
// reset: rst_n clears pose, counts, time and drop counter, and loads register defaults
// top level of the differential drive odometry block
module diff_drive_odometry_top
    import odo_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    odo_meas_if.sink             meas,
    odo_pose_if.source           pose
);

    // command and status between the sequencer and the datapath
    cmd_t  cmd;
    stat_t stat;

    // sequencer: walks check, speeds, plausibility, turn, cordic and commit steps
    odo_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .meas_valid (meas.valid),
        .meas_ready (meas.ready),
        .pose_valid (pose.valid),
        .pose_ready (pose.ready),
        .stat       (stat),
        .cmd        (cmd)
    );

    // datapath: holds config, pose state, the multipliers and the cordic unit;
    // the result register keeps the last beat while the next one is worked on
    odo_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .left_count  (meas.left_count),
        .right_count (meas.right_count),
        .left_speed  (meas.left_speed),
        .right_speed (meas.right_speed),
        .sample_time (meas.sample_time),
        .cmd         (cmd),
        .stat        (stat),
        .pos_x       (pose.pos_x),
        .pos_y       (pose.pos_y),
        .heading     (pose.heading),
        .lin_speed   (pose.lin_speed),
        .rot_speed   (pose.rot_speed),
        .status      (pose.status)
    );

endmodule

@@ rtl/core/odo_checker.sv @@
// port-level checks for the odometry block, bound to the top level
module odo_checker
    import odo_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] pos_x,
    input logic [31:0] pos_y,
    input logic [31:0] heading,
    input logic [31:0] lin_speed,
    input logic [31:0] rot_speed,
    input logic [2:0]  status
);

    // one beat in flight: busy right after taking a beat
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("input taken while busy");

    // rejected beats carry no speed
    a_reject_no_speed: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == RS_STALE || status == RS_ZERO)
        |-> lin_speed == 32'd0 && rot_speed == 32'd0)
        else $error("speed on rejected beat");

    // first beat clears the pose
    a_init_pose: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == RS_INIT |-> pos_x == 32'd0 && pos_y == 32'd0 && heading == 32'd0)
        else $error("pose not cleared on init");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) && $stable(pos_x))
        else $error("result changed under stall");

endmodule

bind diff_drive_odometry_top odo_checker u_odo_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (meas.valid),
    .in_ready  (meas.ready),
    .out_valid (pose.valid),
    .out_ready (pose.ready),
    .pos_x     (pose.pos_x),
    .pos_y     (pose.pos_y),
    .heading   (pose.heading),
    .lin_speed (pose.lin_speed),
    .rot_speed (pose.rot_speed),
    .status    (pose.status)
);

@@ tb/diff_drive_odometry_top_tb.sv @@
// self-checking testbench for the differential drive odometry block
`timescale 1ns / 100ps

module diff_drive_odometry_top_tb;
    import odo_pkg::*;

    // one measurement beat as driven on the input channel
    typedef struct packed {
        logic signed [15:0] left_count;
        logic signed [15:0] right_count;
        logic signed [15:0] left_speed;
        logic signed [15:0] right_speed;
        logic [47:0]        sample_time;
    } meas_t;

    // one pose beat as expected on the output channel
    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] heading;
        logic signed [31:0] lin_speed;
        logic signed [31:0] rot_speed;
        res_status_t        status;
    } pose_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    odo_meas_if meas ();
    odo_pose_if pose ();

    diff_drive_odometry_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .meas      (meas.sink),
        .pose      (pose.source)
    );

    // arctangent steps of the rotation sequence, binary angle units
    int unsigned atan_rom [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886,
        83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
        81, 41, 20, 10, 5, 3, 1, 1, 0
    };

    // predictor copy of the configuration registers
    logic [31:0] cfg_dpt;
    logic [23:0] cfg_apt;
    logic [23:0] cfg_mwr;
    logic [30:0] cfg_mts;
    logic [3:0]  cfg_dlim;
    logic [31:0] cfg_speed;
    logic [31:0] cfg_turn;

    // predictor copy of the odometry state
    logic signed [15:0] last_left;
    logic signed [15:0] last_right;
    bit                 odo_started;
    logic [3:0]         drop_cnt;
    logic [47:0]        last_time;
    logic signed [31:0] acc_x;
    logic signed [31:0] acc_y;
    logic [31:0]        acc_hdg;

    pose_t expected_poses [$];
    int    error_count;
    int    beats_sent;
    int    beats_checked;
    int    status_seen [5];
    bit    send_idling;
    bit    recv_idling;

    // stimulus walk: current counts and time
    logic signed [15:0] walk_left;
    logic signed [15:0] walk_right;
    logic [47:0]        walk_time;

    // clock, period 2 ns
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // run limit, far above the slowest correct run
    initial
    begin
        #8000000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    // undo 16-bit encoder rollover into a signed step
    function automatic int unfold_step(input logic signed [15:0] d);
        int v;
        v = d;
        if (v > 16383)
            v -= 32768;
        if (v < -16383)
            v += 32768;
        return v;
    endfunction

    // true when a wheel step exceeds the believable rate over dt
    function automatic bit wheel_too_fast(input int d, input logic [47:0] dt);
        logic [79:0] a;
        logic [79:0] lim;
        a = (d < 0) ? -d : d;
        a = a * 1000000;
        lim = cfg_mwr;
        lim = lim * dt;
        return a > lim;
    endfunction

    // anomaly: drop while under the limit, else clear and accept
    function automatic bit drop_anomaly();
        if (drop_cnt < cfg_dlim)
        begin
            drop_cnt = drop_cnt + 4'd1;
            return 1'b1;
        end
        drop_cnt = 4'd0;
        return 1'b0;
    endfunction

    // cos and sin of a binary angle in Q1.30 by fixed-gain rotation
    task automatic heading_cos_sin(input logic [31:0] ang, output longint c,
                                   output longint s);
        longint x;
        longint y;
        longint z;
        longint t;
        bit     flip;
        x = 64'sd652032874;
        y = 0;
        flip = 1'b0;
        // fold the left half-plane onto the right one
        if (ang >= 32'h4000_0000 && ang < 32'hC000_0000)
        begin
            ang = ang + 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(ang));
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++)
        begin
            if (z >= 0)
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                z = z - longint'(atan_rom[i]);
            end
            else
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                z = z + longint'(atan_rom[i]);
            end
            x = t;
        end
        c = flip ? -x : x;
        s = flip ? -y : y;
    endtask

    // advance the pose predictor by one accepted beat and queue the result
    task automatic integrate_beat(input meas_t m);
        longint      lin;
        longint      rot;
        longint      step_len;
        longint      c;
        longint      s;
        longint      turn;
        int          dl;
        int          dr;
        int          dd;
        logic [47:0] dt;
        logic [79:0] mag;
        bit          drop;
        res_status_t st;
        pose_t       p;
        lin = 0;
        rot = 0;
        if (last_time >= m.sample_time)
            st = RS_STALE;
        else if (m.left_count == 0 || m.right_count == 0)
            st = RS_ZERO;
        else
        begin
            lin = clip32(((longint'(m.left_speed) + longint'(m.right_speed))
                          * longint'(cfg_speed) + 64'sd1) >>> 1);
            rot = clip32((longint'(m.right_speed) - longint'(m.left_speed))
                         * longint'(cfg_turn));
            lin = longint'($signed(lin[31:0]));
            rot = longint'($signed(rot[31:0]));
            if (!odo_started)
            begin
                last_left = m.left_count;
                last_right = m.right_count;
                odo_started = 1'b1;
                acc_x = 0;
                acc_y = 0;
                acc_hdg = 0;
                st = RS_INIT;
            end
            else
            begin
                dl = unfold_step(m.left_count - last_left);
                dr = unfold_step(m.right_count - last_right);
                dt = m.sample_time - last_time;
                dd = dl - dr;
                mag = (dd < 0) ? -dd : dd;
                mag = mag * cfg_dpt;
                mag = mag * 1000;
                turn = 0;
                drop = 1'b0;
                if (wheel_too_fast(dl, dt) || wheel_too_fast(dr, dt))
                    drop = drop_anomaly();
                if (!drop)
                begin
                    // turns under 1 mm of wheel path are ignored
                    if (mag >= 80'h1_0000_0000)
                        turn = longint'(dd) * longint'(cfg_apt);
                    if (turn > longint'(cfg_mts))
                        drop = drop_anomaly();
                end
                if (drop)
                    st = RS_DROPPED;
                else
                begin
                    step_len = (longint'(dl + dr) * longint'(cfg_dpt) + 64'sd65536) >>> 17;
                    heading_cos_sin(acc_hdg, c, s);
                    acc_x = clip32(longint'(acc_x)
                                   + ((step_len * c + 64'sd536870912) >>> 30));
                    acc_y = clip32(longint'(acc_y)
                                   + ((step_len * s + 64'sd536870912) >>> 30));
                    acc_hdg = acc_hdg + turn[31:0];
                    last_left = m.left_count;
                    last_right = m.right_count;
                    last_time = m.sample_time;
                    if (drop_cnt > 0)
                        drop_cnt = drop_cnt - 4'd1;
                    st = RS_UPDATED;
                end
            end
        end
        p.pos_x = acc_x;
        p.pos_y = acc_y;
        p.heading = acc_hdg;
        p.lin_speed = lin[31:0];
        p.rot_speed = rot[31:0];
        p.status = st;
        expected_poses.push_back(p);
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %0d (0x%h) expected %0d (0x%h)", $realtime,
                 what, $signed(got), got, $signed(want), want);
    endtask

    // result checker: every pose beat against the oldest expectation
    always @(posedge clk)
    begin
        pose_t want;
        if (rst_n && pose.valid && pose.ready)
        begin
            if (expected_poses.size() == 0)
                report_mismatch("unexpected beat status", 32'(pose.status), 32'd0);
            else
            begin
                want = expected_poses.pop_front();
                beats_checked++;
                if (want.status <= RS_INIT)
                    status_seen[want.status]++;
                if (pose.pos_x !== want.pos_x)
                    report_mismatch("pos_x", pose.pos_x, want.pos_x);
                if (pose.pos_y !== want.pos_y)
                    report_mismatch("pos_y", pose.pos_y, want.pos_y);
                if (pose.heading !== want.heading)
                    report_mismatch("heading", pose.heading, want.heading);
                if (pose.lin_speed !== want.lin_speed)
                    report_mismatch("lin_speed", pose.lin_speed, want.lin_speed);
                if (pose.rot_speed !== want.rot_speed)
                    report_mismatch("rot_speed", pose.rot_speed, want.rot_speed);
                if (pose.status !== want.status)
                    report_mismatch("status", 32'(pose.status), 32'(want.status));
            end
        end
    end

    // receiver back-pressure, changed on the falling edge
    initial
    begin
        pose.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            pose.ready = recv_idling ? ($urandom_range(0, 99) >= 26) : 1'b1;
        end
    end

    // send one measurement beat and predict its pose once accepted
    task automatic send_meas(input logic signed [15:0] lc, input logic signed [15:0] rc,
                             input logic signed [15:0] ls, input logic signed [15:0] rs,
                             input logic [47:0] t);
        meas_t m;
        if (send_idling)
        begin
            while ($urandom_range(0, 99) < 26)
            begin
                meas.valid = 1'b0;
                @(negedge clk);
            end
        end
        m = {lc, rc, ls, rs, t};
        meas.valid = 1'b1;
        meas.left_count = lc;
        meas.right_count = rc;
        meas.left_speed = ls;
        meas.right_speed = rs;
        meas.sample_time = t;
        @(posedge clk);
        while (!meas.ready)
            @(posedge clk);
        integrate_beat(m);
        beats_sent++;
        @(negedge clk);
        meas.valid = 1'b0;
    endtask

    // hold the sender until every queued pose has come back
    task automatic drain_poses();
        while (expected_poses.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // register write, only called while the block is idle
    task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_wdata = val;
        @(negedge clk);
        cfg_we = 1'b0;
        case (idx)
            CFG_DIST_PER_TICK:  cfg_dpt = val;
            CFG_ANGLE_PER_TICK: cfg_apt = val[23:0];
            CFG_MAX_WHEEL_RATE: cfg_mwr = val[23:0];
            CFG_MAX_TURN_STEP:  cfg_mts = val[30:0];
            CFG_DROP_LIMIT:     cfg_dlim = val[3:0];
            CFG_SPEED_SCALE:    cfg_speed = val;
            CFG_TURN_SCALE:     cfg_turn = val;
            default: ;
        endcase
    endtask

    task automatic write_all_regs(input logic [31:0] dpt, input logic [31:0] apt,
                                  input logic [31:0] mwr, input logic [31:0] mts,
                                  input logic [31:0] dlim, input logic [31:0] spd,
                                  input logic [31:0] trn);
        drain_poses();
        write_reg(CFG_DIST_PER_TICK, dpt);
        write_reg(CFG_ANGLE_PER_TICK, apt);
        write_reg(CFG_MAX_WHEEL_RATE, mwr);
        write_reg(CFG_MAX_TURN_STEP, mts);
        write_reg(CFG_DROP_LIMIT, dlim);
        write_reg(CFG_SPEED_SCALE, spd);
        write_reg(CFG_TURN_SCALE, trn);
    endtask

    // step the walk and send it, skipping a zero count
    task automatic send_walk(input int dl, input int dr, input int dt);
        walk_left = walk_left + dl[15:0];
        walk_right = walk_right + dr[15:0];
        if (walk_left == 0)
            walk_left = 16'sd1;
        if (walk_right == 0)
            walk_right = -16'sd1;
        walk_time = walk_time + dt;
        send_meas(walk_left, walk_right, 16'($urandom), 16'($urandom), walk_time);
    endtask

    task automatic test_directed();
        // a zero timestamp is always stale
        send_meas(16'sd5, 16'sd5, 16'sd1, 16'sd1, 48'd0);
        // zero counts on either side
        send_meas(16'sd0, 16'sd7, 16'sd3, 16'sd4, 48'd10);
        send_meas(16'sd9, 16'sd0, 16'sd3, 16'sd4, 48'd10);
        // first valid beat only initializes
        send_meas(16'sd100, 16'sd100, 16'sh7FFF, -16'sh8000, 48'd1000);
        send_meas(16'sd200, 16'sd150, -16'sh8000, 16'sh7FFF, 48'd20000);
        // equal timestamp is stale too
        send_meas(16'sd300, 16'sd300, 16'sd0, 16'sd0, 48'd20000);
        // rollover on both wheels
        send_meas(16'sh7FFF, -16'sh8000, 16'sd10, -16'sd10, 48'd70000);
        // wheel step far too fast for the time step
        send_meas(-16'sd22768, -16'sh8000, 16'sd0, 16'sd0, 48'd71000);
        // two large negative turn steps in a row
        send_meas(16'sh7FFF - 16'sd6000, -16'sh8000, 16'sd0, 16'sd0, 48'd1071000);
        send_meas(16'sd26767, -16'sh7FFF + 16'sd6000, 16'sd0, 16'sd0, 48'd2071000);
        // sub-millimeter turn: heading unchanged
        send_meas(16'sd26770, -16'sh7FFF + 16'sd6000, 16'sd0, 16'sd0, 48'd2100000);
        drain_poses();
        // speed scaling with saturation, and a drop limit of zero
        write_reg(CFG_SPEED_SCALE, 32'hFFFF_FFFF);
        write_reg(CFG_TURN_SCALE, 32'h0001_0000);
        write_reg(CFG_DROP_LIMIT, 32'd0);
        send_meas(16'sd26800, -16'sd26000, 16'sh7FFF, 16'sh7FFF, 48'd2200000);
        send_meas(16'sd26900, -16'sd25900, -16'sh8000, 16'sh7FFF, 48'd2300000);
        send_meas(16'sd1000, 16'sd1000, -16'sd1, 16'sd0, 48'd2301000);
        send_meas(16'sd1001, 16'sd999, 16'sd1, -16'sd1, 48'd2400000);
        walk_left = 16'sd1001;
        walk_right = 16'sd999;
        walk_time = 48'd2400000;
    endtask

    // mostly believable motion, with anomalies, stale and zero beats and noise
    task automatic test_random_motion(input int n, input int step);
        int kind;
        int dt;
        for (int k = 0; k < n; k++)
        begin
            kind = $urandom_range(0, 99);
            dt = $urandom_range(500, 60000);
            if (kind < 78)
                send_walk($urandom_range(0, 2 * step) - step,
                          $urandom_range(0, 2 * step) - step, dt);
            else if (kind < 86)
                // wheel jump or hard turn, likely dropped
                send_walk($urandom_range(0, 32767) - 16383,
                          $urandom_range(0, 32767) - 16383, $urandom_range(1, 2000000));
            else if (kind < 91)
                send_meas(walk_left + 16'sd3, walk_right, 16'($urandom), 16'($urandom),
                          walk_time - $urandom_range(0, 3));
            else if (kind < 95)
                send_meas(($urandom_range(0, 1) ? 16'sd0 : walk_left),
                          ($urandom_range(0, 1) ? walk_right : 16'sd0), 16'($urandom),
                          16'($urandom), walk_time + 48'd5);
            else
            begin
                // fully random counts
                walk_time = walk_time + dt;
                send_meas(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                          walk_time);
            end
            // now and then hold off until the pipeline is empty
            if ($urandom_range(0, 199) == 0)
                drain_poses();
        end
    endtask

    task automatic test_default_regs();
        test_random_motion(485, 2500);
    endtask

    task automatic test_random_regs();
        for (int ph = 0; ph < 3; ph++)
        begin
            write_all_regs($urandom_range(1000, 400000), $urandom_range(0, 24'hFFFFFF),
                           $urandom_range(1000, 400000), $urandom >> 1, $urandom_range(0, 15),
                           $urandom >> $urandom_range(8, 31), $urandom >> $urandom_range(8, 31));
            test_random_motion(150, 3000);
        end
    endtask

    task automatic test_reg_extremes();
        write_all_regs(32'hFFFF_FFFF, 32'h00FF_FFFF, 32'h00FF_FFFF, 32'h7FFF_FFFF,
                       32'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        test_random_motion(200, 16000);
        write_all_regs(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        test_random_motion(150, 40);
    endtask

    task automatic test_no_idling();
        write_all_regs(DPT_RESET, APT_RESET, MWR_RESET, MTS_RESET, DLIM_RESET,
                       32'h0000_4000, 32'h0000_0100);
        send_idling = 1'b0;
        recv_idling = 1'b0;
        test_random_motion(150, 2000);
        send_idling = 1'b1;
        recv_idling = 1'b1;
    endtask

    task automatic test_time_top();
        // timestamps close to the top of the 48-bit range
        drain_poses();
        walk_time = 48'hFFFF_F000_0000;
        test_random_motion(100, 2000);
        send_walk(5, 5, int'(48'hFFFF_FFFF_FFFF - walk_time));
    endtask

    initial
    begin
        error_count = 0;
        beats_sent = 0;
        beats_checked = 0;
        foreach (status_seen[i])
            status_seen[i] = 0;
        send_idling = 1'b1;
        recv_idling = 1'b1;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        meas.valid = 1'b0;
        meas.left_count = '0;
        meas.right_count = '0;
        meas.left_speed = '0;
        meas.right_speed = '0;
        meas.sample_time = '0;
        // predictor state after reset
        cfg_dpt = DPT_RESET;
        cfg_apt = APT_RESET;
        cfg_mwr = MWR_RESET;
        cfg_mts = MTS_RESET;
        cfg_dlim = DLIM_RESET;
        cfg_speed = '0;
        cfg_turn = '0;
        last_left = '0;
        last_right = '0;
        odo_started = 1'b0;
        drop_cnt = '0;
        last_time = '0;
        acc_x = '0;
        acc_y = '0;
        acc_hdg = '0;
        walk_left = 16'sd1;
        walk_right = 16'sd1;
        walk_time = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_default_regs();
        test_random_regs();
        test_reg_extremes();
        test_no_idling();
        test_time_top();

        // let the last beats come back, then idle before the summary
        drain_poses();
        repeat (50) @(negedge clk);
        $display("sent %0d measurement beats, checked %0d pose beats", beats_sent,
                 beats_checked);
        $display("updated %0d, dropped %0d, stale %0d, zero count %0d, initialized %0d",
                 status_seen[RS_UPDATED], status_seen[RS_DROPPED], status_seen[RS_STALE],
                 status_seen[RS_ZERO], status_seen[RS_INIT]);
        if (error_count == 0 && expected_poses.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/odo_pkg.sv
rtl/core/odo_ifs.sv
rtl/core/odo_ctrl.sv
rtl/core/odo_dp.sv
rtl/core/diff_drive_odometry_top.sv
rtl/core/odo_checker.sv
tb/diff_drive_odometry_top_tb.sv
